// ===== sv/hsv_grb_pkg.sv =====
// shared constants and helpers for the hsv to grb led word converter
package hsv_grb_pkg;

  localparam int INDEX_WIDTH = 16;
  localparam int POS_WIDTH   = 16;

  // mask that keeps the low INDEX_WIDTH bits of the led index
  localparam logic [POS_WIDTH-1:0] IDX_MASK =
    POS_WIDTH'((64'd1 << INDEX_WIDTH) - 64'd1);

  localparam logic OP_HSV = 1'b0;
  localparam logic OP_RGB = 1'b1;

  localparam logic [7:0] SECTOR_SPAN = 8'd43;
  localparam logic [7:0] CHAN_MAX    = 8'd255;

  localparam logic [2:0] SEC_0 = 3'd0;
  localparam logic [2:0] SEC_1 = 3'd1;
  localparam logic [2:0] SEC_2 = 3'd2;
  localparam logic [2:0] SEC_3 = 3'd3;
  localparam logic [2:0] SEC_4 = 3'd4;
  localparam logic [2:0] SEC_5 = 3'd5;

  function automatic logic [7:0] bit_flip8(input logic [7:0] x);
    logic [7:0] y;
    for (int i = 0; i < 8; i++) begin
      y[i] = x[7-i];
    end
    return y;
  endfunction

endpackage

// ===== sv/hsv_to_grb_led_word.sv =====
// hsv or rgb colour to grb led pixel word, four-stage pipeline
//
// input channel: a transaction is taken at a rising edge with start high and
// busy low. busy is always low: the pipeline never stalls, so a new colour
// can be given in every cycle. in_opcode selects hsv (hue, sat, val) or rgb
// (red, green, blue) on the three 8-bit colour ports.
// result channel: out_valid is high for exactly one cycle per transaction,
// with the index, the three channel levels and the packed 24-bit word.
// a transaction is registered in stage 1, stage 2, stage 3 and then in the
// output registers, from which the receiver takes it. throughput is one
// transaction per cycle, set by the two rows of 8x8 multipliers (stage 2 and
// stage 3) each being registered.
// stages: 1 sector and remainder, 2 first products, 3 second products,
// 4 sector select, bit reversal and packing into the output registers.
// the receiver cannot hold results off, so nothing waits inside.
// reset clears the stage valid bits only; no result appears until new input.
module hsv_to_grb_led_word
  import hsv_grb_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_opcode,
  input  logic [POS_WIDTH-1:0] in_led_index,
  input  logic [7:0]           in_hue_or_red,
  input  logic [7:0]           in_sat_or_green,
  input  logic [7:0]           in_val_or_blue,
  output logic                 out_valid,
  output logic [POS_WIDTH-1:0] out_led_position,
  output logic [7:0]           out_red_level,
  output logic [7:0]           out_green_level,
  output logic [7:0]           out_blue_level,
  output logic [23:0]          out_pixel_word
);

  // stage 1
  logic                 s1_valid_r;
  logic                 s1_op_r;
  logic [POS_WIDTH-1:0] s1_idx_r;
  logic [7:0]           s1_a_r, s1_b_r, s1_c_r;
  logic [2:0]           s1_sec_r;
  logic [7:0]           s1_rem_r;
  logic [2:0]           s1_sec_nxt;
  logic [7:0]           s1_base;
  logic [5:0]           s1_diff;

  // stage 2
  logic                 s2_valid_r;
  logic                 s2_op_r;
  logic [POS_WIDTH-1:0] s2_idx_r;
  logic [7:0]           s2_a_r, s2_b_r, s2_c_r;
  logic [2:0]           s2_sec_r;
  logic [15:0]          s2_pp_r, s2_sq_r, s2_st_r;

  // stage 3
  logic                 s3_valid_r;
  logic                 s3_op_r;
  logic [POS_WIDTH-1:0] s3_idx_r;
  logic [7:0]           s3_a_r, s3_b_r, s3_c_r;
  logic [2:0]           s3_sec_r;
  logic [7:0]           s3_p_r;
  logic [15:0]          s3_qp_r, s3_tp_r;
  logic [7:0]           s3_qa, s3_ta;

  // stage 4 selection
  logic [7:0] red_nxt, green_nxt, blue_nxt;
  logic [7:0] q_v, t_v, v_v;

  logic                 out_valid_r;
  logic [POS_WIDTH-1:0] out_led_position_r;
  logic [7:0]           out_red_level_r, out_green_level_r, out_blue_level_r;
  logic [23:0]          out_pixel_word_r;

  assign busy = 1'b0;

  // hue / 43 by threshold compares
  always_comb begin
    if (in_hue_or_red >= 8'(5 * SECTOR_SPAN)) begin
      s1_sec_nxt = SEC_5;
    end else if (in_hue_or_red >= 8'(4 * SECTOR_SPAN)) begin
      s1_sec_nxt = SEC_4;
    end else if (in_hue_or_red >= 8'(3 * SECTOR_SPAN)) begin
      s1_sec_nxt = SEC_3;
    end else if (in_hue_or_red >= 8'(2 * SECTOR_SPAN)) begin
      s1_sec_nxt = SEC_2;
    end else if (in_hue_or_red >= SECTOR_SPAN) begin
      s1_sec_nxt = SEC_1;
    end else begin
      s1_sec_nxt = SEC_0;
    end
    s1_base = 8'(s1_sec_nxt * SECTOR_SPAN);
    s1_diff = 6'(in_hue_or_red - s1_base);
  end

  assign s3_qa = CHAN_MAX - s2_sq_r[15:8];
  assign s3_ta = CHAN_MAX - s2_st_r[15:8];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= start && !busy;
      s2_valid_r  <= s1_valid_r;
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_op_r  <= in_opcode;
    s1_idx_r <= in_led_index & IDX_MASK;
    s1_a_r   <= in_hue_or_red;
    s1_b_r   <= in_sat_or_green;
    s1_c_r   <= in_val_or_blue;
    s1_sec_r <= s1_sec_nxt;
    s1_rem_r <= 8'({2'b00, s1_diff} * 8'd6);

    s2_op_r  <= s1_op_r;
    s2_idx_r <= s1_idx_r;
    s2_a_r   <= s1_a_r;
    s2_b_r   <= s1_b_r;
    s2_c_r   <= s1_c_r;
    s2_sec_r <= s1_sec_r;
    s2_pp_r  <= s1_c_r * (CHAN_MAX - s1_b_r);
    s2_sq_r  <= s1_b_r * s1_rem_r;
    s2_st_r  <= s1_b_r * (CHAN_MAX - s1_rem_r);

    s3_op_r  <= s2_op_r;
    s3_idx_r <= s2_idx_r;
    s3_a_r   <= s2_a_r;
    s3_b_r   <= s2_b_r;
    s3_c_r   <= s2_c_r;
    s3_sec_r <= s2_sec_r;
    s3_p_r   <= s2_pp_r[15:8];
    s3_qp_r  <= s2_c_r * s3_qa;
    s3_tp_r  <= s2_c_r * s3_ta;
  end

  assign q_v = s3_qp_r[15:8];
  assign t_v = s3_tp_r[15:8];
  assign v_v = s3_c_r;

  always_comb begin
    red_nxt   = v_v;
    green_nxt = s3_p_r;
    blue_nxt  = q_v;
    if (s3_op_r == OP_RGB) begin
      red_nxt   = s3_a_r;
      green_nxt = s3_b_r;
      blue_nxt  = s3_c_r;
    end else if (s3_b_r == 8'd0) begin
      // grey: no saturation
      red_nxt   = v_v;
      green_nxt = v_v;
      blue_nxt  = v_v;
    end else begin
      case (s3_sec_r)
        SEC_0: begin
          red_nxt = v_v;    green_nxt = t_v;    blue_nxt = s3_p_r;
        end
        SEC_1: begin
          red_nxt = q_v;    green_nxt = v_v;    blue_nxt = s3_p_r;
        end
        SEC_2: begin
          red_nxt = s3_p_r; green_nxt = v_v;    blue_nxt = t_v;
        end
        SEC_3: begin
          red_nxt = s3_p_r; green_nxt = q_v;    blue_nxt = v_v;
        end
        SEC_4: begin
          red_nxt = t_v;    green_nxt = s3_p_r; blue_nxt = v_v;
        end
        default: begin
          red_nxt = v_v;    green_nxt = s3_p_r; blue_nxt = q_v;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    out_led_position_r <= s3_idx_r;
    out_red_level_r    <= red_nxt;
    out_green_level_r  <= green_nxt;
    out_blue_level_r   <= blue_nxt;
    out_pixel_word_r   <= {bit_flip8(blue_nxt), bit_flip8(red_nxt), bit_flip8(green_nxt)};
  end

  assign out_valid        = out_valid_r;
  assign out_led_position = out_led_position_r;
  assign out_red_level    = out_red_level_r;
  assign out_green_level  = out_green_level_r;
  assign out_blue_level   = out_blue_level_r;
  assign out_pixel_word   = out_pixel_word_r;

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for the hsv/rgb to grb led pixel word converter
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import hsv_grb_pkg::*;

  typedef struct packed {
    logic [POS_WIDTH-1:0] pos;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic [23:0]          word;
  } led_pixel_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 in_opcode = OP_HSV;
  logic [POS_WIDTH-1:0] in_led_index = '0;
  logic [7:0]           in_hue_or_red = '0;
  logic [7:0]           in_sat_or_green = '0;
  logic [7:0]           in_val_or_blue = '0;
  logic                 out_valid;
  logic [POS_WIDTH-1:0] out_led_position;
  logic [7:0]           out_red_level;
  logic [7:0]           out_green_level;
  logic [7:0]           out_blue_level;
  logic [23:0]          out_pixel_word;

  led_pixel_t  pending_pixels[$];
  int unsigned idle_pct = 0;
  int unsigned mismatch_count = 0;
  int unsigned checked_count = 0;
  int unsigned hsv_sent = 0;
  int unsigned rgb_sent = 0;
  int unsigned gray_sent = 0;

  hsv_to_grb_led_word dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_opcode        (in_opcode),
    .in_led_index     (in_led_index),
    .in_hue_or_red    (in_hue_or_red),
    .in_sat_or_green  (in_sat_or_green),
    .in_val_or_blue   (in_val_or_blue),
    .out_valid        (out_valid),
    .out_led_position (out_led_position),
    .out_red_level    (out_red_level),
    .out_green_level  (out_green_level),
    .out_blue_level   (out_blue_level),
    .out_pixel_word   (out_pixel_word)
  );

  always #2 clk = ~clk;

  function automatic logic [7:0] mirror_byte(logic [7:0] x);
    logic [7:0] y;
    for (int i = 0; i < 8; i++) y[i] = x[7-i];
    return y;
  endfunction

  // integer six-sector hsv conversion, rgb passes straight through
  function automatic led_pixel_t convert_colour(logic op, logic [POS_WIDTH-1:0] idx,
                                                logic [7:0] a, logic [7:0] b,
                                                logic [7:0] c);
    led_pixel_t  res;
    int unsigned sector, rem, p, q, t, v, s;
    logic [7:0]  r8, g8, b8;
    v = c;
    s = b;
    if (op == OP_RGB) begin
      r8 = a; g8 = b; b8 = c;
    end else if (s == 0) begin
      r8 = c; g8 = c; b8 = c;
    end else begin
      sector = a / SECTOR_SPAN;
      rem = (a - sector * SECTOR_SPAN) * 6;
      p = ((v * (CHAN_MAX - s)) >> 8) & 8'hFF;
      q = ((v * (CHAN_MAX - ((s * rem) >> 8))) >> 8) & 8'hFF;
      t = ((v * (CHAN_MAX - ((s * (CHAN_MAX - rem)) >> 8))) >> 8) & 8'hFF;
      case (sector[2:0])
        SEC_0: begin r8 = 8'(v); g8 = 8'(t); b8 = 8'(p); end
        SEC_1: begin r8 = 8'(q); g8 = 8'(v); b8 = 8'(p); end
        SEC_2: begin r8 = 8'(p); g8 = 8'(v); b8 = 8'(t); end
        SEC_3: begin r8 = 8'(p); g8 = 8'(q); b8 = 8'(v); end
        SEC_4: begin r8 = 8'(t); g8 = 8'(p); b8 = 8'(v); end
        default: begin r8 = 8'(v); g8 = 8'(p); b8 = 8'(q); end
      endcase
    end
    res.pos   = idx & IDX_MASK;
    res.red   = r8;
    res.green = g8;
    res.blue  = b8;
    res.word  = {mirror_byte(b8), mirror_byte(r8), mirror_byte(g8)};
    return res;
  endfunction

  task automatic log_failure(string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("%0t: %s", $realtime, msg);
  endtask

  // results are sampled at the edge that ends their strobe cycle
  always @(posedge clk) begin
    led_pixel_t got;
    led_pixel_t want;
    if (rst_n && out_valid === 1'b1) begin
      got = {out_led_position, out_red_level, out_green_level, out_blue_level,
             out_pixel_word};
      if (pending_pixels.size() == 0) begin
        log_failure($sformatf("result with no transaction pending: pos=%h word=%h",
                              got.pos, got.word));
      end else begin
        want = pending_pixels.pop_front();
        checked_count++;
        if (got !== want)
          log_failure($sformatf({"mismatch: exp pos=%h r=%h g=%h b=%h word=%h",
                                 " got pos=%h r=%h g=%h b=%h word=%h"},
                                want.pos, want.red, want.green, want.blue, want.word,
                                got.pos, got.red, got.green, got.blue, got.word));
      end
    end
  end

  // called right after an edge; returns at the edge that took the transaction
  task automatic send_colour(logic op, logic [POS_WIDTH-1:0] idx, logic [7:0] a,
                             logic [7:0] b, logic [7:0] c);
    // each cycle idles with probability idle_pct percent
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    in_opcode       <= op;
    in_led_index    <= idx;
    in_hue_or_red   <= a;
    in_sat_or_green <= b;
    in_val_or_blue  <= c;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    pending_pixels.push_back(convert_colour(op, idx, a, b, c));
    if (op == OP_RGB) rgb_sent++;
    else begin
      hsv_sent++;
      if (b == 8'd0) gray_sent++;
    end
  endtask

  task automatic wait_results_drained();
    start <= 1'b0;
    do @(posedge clk); while (pending_pixels.size() != 0);
  endtask

  task automatic test_directed_corners();
    logic [7:0] hue_edges[12] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd128,
                                  8'd129, 8'd171, 8'd172, 8'd214, 8'd215, 8'd255};
    send_colour(OP_RGB, 16'h0000, 8'h00, 8'h00, 8'h00);
    send_colour(OP_RGB, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_colour(OP_RGB, 16'hA5A5, 8'hAA, 8'h55, 8'h0F);
    send_colour(OP_RGB, 16'h5A5A, 8'h01, 8'h80, 8'hF0);
    // zero saturation gives a gray level
    send_colour(OP_HSV, 16'h0001, 8'd100, 8'd0, 8'd200);
    send_colour(OP_HSV, 16'h8000, 8'd255, 8'd0, 8'd255);
    // both sides of every sector boundary, hue top end lands in the default sector
    foreach (hue_edges[i]) send_colour(OP_HSV, 16'(i), hue_edges[i], 8'd255, 8'd255);
    send_colour(OP_HSV, 16'h1234, 8'd20, 8'd1, 8'd255);
    send_colour(OP_HSV, 16'h4321, 8'd50, 8'd255, 8'd0);
    send_colour(OP_HSV, 16'h7FFF, 8'd230, 8'd128, 8'd128);
    wait_results_drained();
  endtask

  task automatic test_random_colours(int unsigned count, int unsigned pct);
    logic       op;
    logic [7:0] a, b, c;
    idle_pct = pct;
    for (int unsigned n = 0; n < count; n++) begin
      op = 1'($urandom_range(0, 1));
      a  = 8'($urandom_range(0, 255));
      b  = ($urandom_range(0, 15) == 0) ? 8'd0 : 8'($urandom_range(0, 255));
      c  = 8'($urandom_range(0, 255));
      send_colour(op, POS_WIDTH'($urandom), a, b, c);
      // pause now and then until the pipeline is empty
      if ($urandom_range(0, 199) == 0) wait_results_drained();
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_corners();
    test_random_colours(630, 12);
    test_random_colours(630, 61);
    test_random_colours(640, 0);
    start <= 1'b0;
    repeat (10) @(posedge clk);
    if (pending_pixels.size() != 0)
      log_failure($sformatf("%0d results never arrived", pending_pixels.size()));
    $display("covered %0d hsv colours (%0d gray) and %0d rgb colours, %0d results checked",
             hsv_sent, gray_sent, rgb_sent, checked_count);
    $display("sender idling at 12%%, 61%% and none, with drain pauses; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400us;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== files.f =====
sv/hsv_grb_pkg.sv
sv/hsv_to_grb_led_word.sv
tb/sv/tb_top.sv
